@@ src/ift_pkg.sv @@
// Shared types and character codes for the input field tokenizer.
`timescale 1ns / 1ps

package ift_pkg;

  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 13;
  localparam int CFG_IDX_W = 2;

  // Largest value the field_limit register can hold.
  localparam int LIMIT_REG_MAX = (1 << LEN_W) - 1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIELD = 2'd1,
    PH_DELIM = 2'd2,
    PH_CR    = 2'd3
  } phase_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STRING_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_LIMIT = 2'd1;

  localparam logic [LEN_W-1:0] FIELD_LIMIT_RESET = 13'd67;

  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_AMP    = 8'h26;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_PERIOD = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_UP_D   = 8'h44;
  localparam logic [CHAR_W-1:0] CH_UP_E   = 8'h45;
  localparam logic [CHAR_W-1:0] CH_LO_D   = 8'h64;
  localparam logic [CHAR_W-1:0] CH_LO_E   = 8'h65;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_file;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              char_valid;
    logic              field_end;
    logic              looks_float;
    logic [LEN_W-1:0]  field_length;
  } result_t;

  // Handshake status between the pipeline stages.
  typedef struct packed {
    logic advance;
    logic emit;
  } stage_ctl_t;

endpackage

@@ src/ift_in_stage.sv @@
// Input register: holds one accepted word until the decode step takes it.
`timescale 1ns / 1ps

module ift_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ift_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output ift_pkg::item_t item
);

  logic           valid_r;
  logic           valid_nxt;
  ift_pkg::item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ src/ift_core.sv @@
// Field state, configuration registers and the per-character decode step.
`timescale 1ns / 1ps

module ift_core #(
  parameter int MAX_FIELD = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ift_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ift_pkg::LEN_W-1:0]        cfg_data,
  input  logic                             item_valid,
  input  ift_pkg::item_t                   item,
  input  logic                             advance,
  output logic                             emit,
  output ift_pkg::result_t                 result
);

  localparam int LimCapInt = (MAX_FIELD < ift_pkg::LIMIT_REG_MAX) ?
                             MAX_FIELD : ift_pkg::LIMIT_REG_MAX;
  localparam logic [ift_pkg::LEN_W-1:0] LimCap = ift_pkg::LEN_W'(LimCapInt);
  localparam logic [ift_pkg::LEN_W-1:0] LenOne = ift_pkg::LEN_W'(1);

  logic                       string_mode_r;
  logic [ift_pkg::LEN_W-1:0]  field_limit_r;

  ift_pkg::phase_t            phase_r, phase_nxt;
  logic                       quote_r, quote_nxt;
  logic                       amp_r, amp_nxt;
  logic                       float_r, float_nxt;
  logic [ift_pkg::LEN_W-1:0]  count_r, count_nxt;

  logic [ift_pkg::LEN_W-1:0]  limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      string_mode_r <= 1'b0;
      field_limit_r <= ift_pkg::FIELD_LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == ift_pkg::CFG_STRING_MODE) begin
        string_mode_r <= cfg_data[0];
      end else if (cfg_index == ift_pkg::CFG_FIELD_LIMIT) begin
        field_limit_r <= cfg_data;
      end
    end
  end

  // Clamp the limit into one to the largest field.
  always_comb begin
    if (field_limit_r == '0) begin
      limit = LenOne;
    end else if (field_limit_r > LimCap) begin
      limit = LimCap;
    end else begin
      limit = field_limit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ift_pkg::PH_IDLE;
      quote_r <= 1'b0;
      amp_r   <= 1'b0;
      float_r <= 1'b0;
      count_r <= '0;
    end else if (item_valid && advance) begin
      phase_r <= phase_nxt;
      quote_r <= quote_nxt;
      amp_r   <= amp_nxt;
      float_r <= float_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    logic [ift_pkg::CHAR_W-1:0] c;
    logic                       eof;
    logic                       blank;
    logic                       do_field;
    logic                       do_keep;
    logic                       do_fin;
    logic                       fin_valid;
    ift_pkg::phase_t            fin_phase;
    logic [ift_pkg::CHAR_W-1:0] kch;
    logic [ift_pkg::LEN_W-1:0]  inc;

    c         = item.char_code;
    eof       = item.end_of_file;
    blank     = (c == ift_pkg::CH_SPACE) || (c == ift_pkg::CH_TAB);
    do_field  = 1'b0;
    do_keep   = 1'b0;
    do_fin    = 1'b0;
    fin_valid = 1'b0;
    fin_phase = ift_pkg::PH_IDLE;
    kch       = c;
    inc       = '0;

    phase_nxt = phase_r;
    quote_nxt = quote_r;
    amp_nxt   = amp_r;
    float_nxt = float_r;
    count_nxt = count_r;
    emit      = 1'b0;
    result    = '0;

    unique case (phase_r)
      ift_pkg::PH_FIELD: begin
        do_field = 1'b1;
      end
      ift_pkg::PH_DELIM: begin
        if (eof || c == ift_pkg::CH_COMMA || c == ift_pkg::CH_LF) begin
          phase_nxt = ift_pkg::PH_IDLE;
        end else if (blank) begin
          phase_nxt = ift_pkg::PH_DELIM;
        end else if (c == ift_pkg::CH_CR) begin
          phase_nxt = ift_pkg::PH_CR;
        end else begin
          phase_nxt = ift_pkg::PH_IDLE;
          do_field  = 1'b1;
        end
      end
      ift_pkg::PH_CR: begin
        phase_nxt = ift_pkg::PH_IDLE;
        if (eof) begin
          emit               = 1'b1;
          result.field_end   = 1'b1;
          result.looks_float = float_r;
          result.field_length = count_r;
        end else if (c != ift_pkg::CH_LF && !blank) begin
          do_field = 1'b1;
        end
      end
      ift_pkg::PH_IDLE: begin
        phase_nxt = ift_pkg::PH_IDLE;
        if (eof) begin
          emit               = 1'b1;
          result.field_end   = 1'b1;
          result.looks_float = float_r;
          result.field_length = count_r;
        end else if (!blank) begin
          do_field = 1'b1;
        end
      end
      default: begin
        phase_nxt = ift_pkg::PH_IDLE;
      end
    endcase

    if (do_field) begin
      // A field started from between fields opens with cleared attributes.
      if (phase_r != ift_pkg::PH_FIELD) begin
        quote_nxt = 1'b0;
        amp_nxt   = 1'b0;
        float_nxt = 1'b0;
        count_nxt = '0;
      end
      phase_nxt = ift_pkg::PH_FIELD;
      if (eof) begin
        do_fin = 1'b1;
      end else begin
        unique case (c)
          ift_pkg::CH_LF: begin
            do_fin = 1'b1;
          end
          ift_pkg::CH_CR: begin
            do_fin    = 1'b1;
            fin_phase = ift_pkg::PH_CR;
          end
          ift_pkg::CH_QUOTE: begin
            if (!quote_nxt) begin
              if (count_nxt == '0) begin
                quote_nxt = 1'b1;
              end else begin
                do_keep = 1'b1;
              end
            end else begin
              // Closing quote: dropped; ends the field in string mode only.
              quote_nxt = 1'b0;
              if (string_mode_r) begin
                do_fin    = 1'b1;
                fin_phase = ift_pkg::PH_DELIM;
              end
            end
          end
          ift_pkg::CH_COMMA: begin
            if (!quote_nxt) begin
              do_fin = 1'b1;
            end else begin
              do_keep = 1'b1;
            end
          end
          ift_pkg::CH_AMP: begin
            amp_nxt = 1'b1;
            do_keep = 1'b1;
          end
          ift_pkg::CH_LO_D, ift_pkg::CH_UP_D: begin
            if (!amp_nxt && !string_mode_r) begin
              kch = c + ift_pkg::CHAR_W'(1);
            end
            if (!amp_nxt) begin
              float_nxt = 1'b1;
            end
            do_keep = 1'b1;
          end
          ift_pkg::CH_LO_E, ift_pkg::CH_UP_E, ift_pkg::CH_PERIOD: begin
            if (!amp_nxt) begin
              float_nxt = 1'b1;
            end
            do_keep = 1'b1;
          end
          ift_pkg::CH_TAB, ift_pkg::CH_SPACE: begin
            if (!quote_nxt && !string_mode_r) begin
              do_fin    = 1'b1;
              fin_phase = ift_pkg::PH_DELIM;
            end else begin
              do_keep = 1'b1;
            end
          end
          default: begin
            do_keep = 1'b1;
          end
        endcase
      end

      if (do_keep) begin
        inc       = count_nxt + LenOne;
        count_nxt = inc;
        if (inc >= limit) begin
          do_fin    = 1'b1;
          fin_valid = 1'b1;
          fin_phase = ift_pkg::PH_DELIM;
        end else begin
          emit              = 1'b1;
          result.out_char   = kch;
          result.char_valid = 1'b1;
        end
      end

      if (do_fin) begin
        emit                = 1'b1;
        result.out_char     = fin_valid ? kch : '0;
        result.char_valid   = fin_valid;
        result.field_end    = 1'b1;
        result.looks_float  = float_nxt;
        result.field_length = count_nxt;
        quote_nxt           = 1'b0;
        amp_nxt             = 1'b0;
        float_nxt           = 1'b0;
        count_nxt           = '0;
        phase_nxt           = fin_phase;
      end
    end
  end

endmodule

@@ src/ift_out_stage.sv @@
// Result register: holds one result word until the consumer takes it.
`timescale 1ns / 1ps

module ift_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  ift_pkg::stage_ctl_t ctl,
  input  ift_pkg::result_t   result,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               room,
  output ift_pkg::result_t   out_result
);

  logic             valid_r;
  logic             valid_nxt;
  logic             load;
  ift_pkg::result_t result_r;

  assign load = ctl.advance && ctl.emit;
  assign room = !valid_r || out_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

@@ src/input_field_tokenizer.sv @@
// Top level of the input field tokenizer: input register, decode step, result register.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------------
//   in      | in_valid / in_ready   | in_char_code[7:0], in_end_of_file
//   out     | out_valid / out_ready | out_char[7:0], out_char_valid, out_field_end,
//           |                       | out_looks_float, out_field_length[12:0]
//   cfg     | cfg_valid / cfg_ready | cfg_index[1:0], cfg_data[12:0]
//
// One word per cycle sustained while out_ready is high. A result reaches out_valid
// via the input and result registers: the word sits in the input register while
// the decode step feeds the result register. The state update for a word happens
// in the same cycle as its decode, so the next word follows straight on. Synchronous
// reset returns to between-fields with string_mode 0 and field_limit 67. A stalled
// consumer holds the result register, then the input register, then in_ready.
`timescale 1ns / 1ps

module input_field_tokenizer #(
  parameter int MAX_FIELD = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ift_pkg::CHAR_W-1:0]    in_char_code,
  input  logic                          in_end_of_file,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ift_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_char_valid,
  output logic                          out_field_end,
  output logic                          out_looks_float,
  output logic [ift_pkg::LEN_W-1:0]     out_field_length,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ift_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ift_pkg::LEN_W-1:0]     cfg_data
);

  ift_pkg::item_t      in_item;
  ift_pkg::item_t      item;
  logic                item_valid;
  logic                room;
  logic                emit;
  ift_pkg::stage_ctl_t ctl;
  ift_pkg::result_t    result;
  ift_pkg::result_t    out_result;

  assign in_item.char_code   = in_char_code;
  assign in_item.end_of_file = in_end_of_file;

  // Advance the decode step whenever the result register has room.
  assign ctl.advance = item_valid && room;
  assign ctl.emit    = emit;

  ift_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (ctl.advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ift_core #(
    .MAX_FIELD (MAX_FIELD)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .advance    (ctl.advance),
    .emit       (emit),
    .result     (result)
  );

  ift_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .result     (result),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .room       (room),
    .out_result (out_result)
  );

  assign out_char         = out_result.out_char;
  assign out_char_valid   = out_result.char_valid;
  assign out_field_end    = out_result.field_end;
  assign out_looks_float  = out_result.looks_float;
  assign out_field_length = out_result.field_length;

endmodule

@@ src/ift_checker.sv @@
// Port-level checks on the tokenizer's result channel, bound to the top level.
`timescale 1ns / 1ps

module ift_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ift_pkg::CHAR_W-1:0] out_char,
  input logic                       out_char_valid,
  input logic                       out_field_end,
  input logic                       out_looks_float,
  input logic [ift_pkg::LEN_W-1:0]  out_field_length
);

  // Out of reset no result word is pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // Hold a stalled result word.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
    $stable(out_char_valid) && $stable(out_field_end) && $stable(out_field_length))
    else $error("stalled result word changed");

  // A word that does not end a field always carries a character and no summary.
  a_mid_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_field_end |->
    out_char_valid && !out_looks_float && out_field_length == '0)
    else $error("mid-field word malformed");

  // A field ended by a kept character has at least that one character.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_end && out_char_valid |-> out_field_length != '0)
    else $error("field ended on a character with zero length");

  // No character means a zero code.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_valid |-> out_char == '0)
    else $error("character code without char_valid");

endmodule

bind input_field_tokenizer ift_checker u_ift_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_char         (out_char),
  .out_char_valid   (out_char_valid),
  .out_field_end    (out_field_end),
  .out_looks_float  (out_looks_float),
  .out_field_length (out_field_length)
);

@@ test/input_field_tokenizer_tb.sv @@
// Self-checking testbench for the input field tokenizer: predicted results, random traffic.
`timescale 1ns / 1ps

module input_field_tokenizer_tb;

  localparam int MAX_FIELD      = 4096;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 12;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_SHOWN      = 30;
  localparam int WORDS_PER_SET  = 105;
  localparam int NUM_SETS       = 8;

  logic                          clk;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_ready;
  logic [ift_pkg::CHAR_W-1:0]    in_char_code   = '0;
  logic                          in_end_of_file = 1'b0;
  logic                          out_valid;
  logic                          out_ready      = 1'b0;
  logic [ift_pkg::CHAR_W-1:0]    out_char;
  logic                          out_char_valid;
  logic                          out_field_end;
  logic                          out_looks_float;
  logic [ift_pkg::LEN_W-1:0]     out_field_length;
  logic                          cfg_valid      = 1'b0;
  logic                          cfg_ready;
  logic [ift_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
  logic [ift_pkg::LEN_W-1:0]     cfg_data       = '0;

  input_field_tokenizer #(.MAX_FIELD(MAX_FIELD)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char         (out_char),
    .out_char_valid   (out_char_valid),
    .out_field_end    (out_field_end),
    .out_looks_float  (out_looks_float),
    .out_field_length (out_field_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Tokenizer state and registers as the testbench sees them
  logic                      str_mode;
  logic [ift_pkg::LEN_W-1:0] lim_reg;
  ift_pkg::phase_t           tok_phase;
  logic                      in_quotes;
  logic                      amp_seen;
  logic                      float_flag;
  int                        kept_len;

  ift_pkg::item_t   send_q[$];
  ift_pkg::result_t field_q[$];

  int error_count    = 0;
  int words_accepted = 0;
  int results_seen   = 0;
  int fields_closed  = 0;
  int cfg_writes     = 0;
  int queued_words   = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int hold_left      = 0;
  int hold_mark      = 40;
  int holds_done     = 0;
  int stall_tick     = 0;
  int idle_cycles    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  function automatic void clear_field();
    in_quotes  = 1'b0;
    amp_seen   = 1'b0;
    float_flag = 1'b0;
    kept_len   = 0;
  endfunction

  function automatic void close_field(input logic [ift_pkg::CHAR_W-1:0] ch,
                                      input logic ch_ok, input ift_pkg::phase_t nxt,
                                      output ift_pkg::result_t r);
    r.out_char     = ch;
    r.char_valid   = ch_ok;
    r.field_end    = 1'b1;
    r.looks_float  = float_flag;
    r.field_length = ift_pkg::LEN_W'(kept_len);
    clear_field();
    tok_phase = nxt;
  endfunction

  function automatic bit keep_char(input logic [ift_pkg::CHAR_W-1:0] ch,
                                   output ift_pkg::result_t r);
    int eff;
    eff = (lim_reg == 0) ? 1 : ((lim_reg > MAX_FIELD) ? MAX_FIELD : int'(lim_reg));
    r = '0;
    kept_len++;
    if (kept_len >= eff) begin
      close_field(ch, 1'b1, ift_pkg::PH_DELIM, r);
    end else begin
      r.out_char   = ch;
      r.char_valid = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic bit field_char(input logic [ift_pkg::CHAR_W-1:0] c, input logic eof,
                                    output ift_pkg::result_t r);
    r = '0;
    if (eof) begin
      close_field('0, 1'b0, ift_pkg::PH_IDLE, r);
      return 1'b1;
    end
    case (c)
      ift_pkg::CH_LF: begin
        close_field('0, 1'b0, ift_pkg::PH_IDLE, r);
        return 1'b1;
      end
      ift_pkg::CH_CR: begin
        close_field('0, 1'b0, ift_pkg::PH_CR, r);
        return 1'b1;
      end
      ift_pkg::CH_QUOTE: begin
        if (!in_quotes) begin
          // only a leading quote opens; a later one is ordinary text
          if (kept_len == 0) begin
            in_quotes = 1'b1;
            return 1'b0;
          end
          return keep_char(c, r);
        end
        in_quotes = 1'b0;
        if (str_mode) begin
          close_field('0, 1'b0, ift_pkg::PH_DELIM, r);
          return 1'b1;
        end
        return 1'b0;
      end
      ift_pkg::CH_COMMA: begin
        if (in_quotes) return keep_char(c, r);
        close_field('0, 1'b0, ift_pkg::PH_IDLE, r);
        return 1'b1;
      end
      ift_pkg::CH_AMP: begin
        amp_seen = 1'b1;
        return keep_char(c, r);
      end
      ift_pkg::CH_LO_D, ift_pkg::CH_UP_D: begin
        if (!amp_seen) begin
          float_flag = 1'b1;
          if (!str_mode) c = c + 8'd1;
        end
        return keep_char(c, r);
      end
      ift_pkg::CH_LO_E, ift_pkg::CH_UP_E, ift_pkg::CH_PERIOD: begin
        if (!amp_seen) float_flag = 1'b1;
        return keep_char(c, r);
      end
      ift_pkg::CH_TAB, ift_pkg::CH_SPACE: begin
        if (in_quotes || str_mode) return keep_char(c, r);
        close_field('0, 1'b0, ift_pkg::PH_DELIM, r);
        return 1'b1;
      end
      default: return keep_char(c, r);
    endcase
  endfunction

  function automatic bit start_field(input logic [ift_pkg::CHAR_W-1:0] c, input logic eof,
                                     output ift_pkg::result_t r);
    r = '0;
    tok_phase = ift_pkg::PH_IDLE;
    if (eof) begin
      r.field_end    = 1'b1;
      r.looks_float  = float_flag;
      r.field_length = ift_pkg::LEN_W'(kept_len);
      return 1'b1;
    end
    if (c == ift_pkg::CH_SPACE || c == ift_pkg::CH_TAB) return 1'b0;
    clear_field();
    tok_phase = ift_pkg::PH_FIELD;
    return field_char(c, 1'b0, r);
  endfunction

  // Advance the tokenizer by one word; returns 1 when the word yields a result
  function automatic bit tokenize(input logic [ift_pkg::CHAR_W-1:0] c, input logic eof,
                                  output ift_pkg::result_t r);
    r = '0;
    case (tok_phase)
      ift_pkg::PH_FIELD: return field_char(c, eof, r);
      ift_pkg::PH_DELIM: begin
        if (eof || c == ift_pkg::CH_COMMA || c == ift_pkg::CH_LF) begin
          tok_phase = ift_pkg::PH_IDLE;
          return 1'b0;
        end
        if (c == ift_pkg::CH_SPACE || c == ift_pkg::CH_TAB) return 1'b0;
        if (c == ift_pkg::CH_CR) begin
          tok_phase = ift_pkg::PH_CR;
          return 1'b0;
        end
        return start_field(c, 1'b0, r);
      end
      ift_pkg::PH_CR: begin
        tok_phase = ift_pkg::PH_IDLE;
        if (!eof && c == ift_pkg::CH_LF) return 1'b0;
        return start_field(c, eof, r);
      end
      default: return start_field(c, eof, r);
    endcase
  endfunction

  function automatic void push_char(input logic [ift_pkg::CHAR_W-1:0] c);
    send_q.push_back(ift_pkg::item_t'{char_code: c, end_of_file: 1'b0});
    queued_words++;
  endfunction

  function automatic void push_eof();
    // the character code rides along with random content and must be ignored
    send_q.push_back(ift_pkg::item_t'{char_code: ift_pkg::CHAR_W'($urandom_range(0, 255)),
                                      end_of_file: 1'b1});
    queued_words++;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endfunction

  function automatic logic [ift_pkg::CHAR_W-1:0] blank_char();
    return $urandom_range(0, 1) ? ift_pkg::CH_SPACE : ift_pkg::CH_TAB;
  endfunction

  function automatic logic [ift_pkg::CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 10))
      0, 1, 2, 3: return ift_pkg::CHAR_W'($urandom_range(33, 126));
      4: begin
        case ($urandom_range(0, 3))
          0: return ift_pkg::CH_LO_D;
          1: return ift_pkg::CH_UP_D;
          2: return ift_pkg::CH_LO_E;
          default: return ift_pkg::CH_UP_E;
        endcase
      end
      5: return ift_pkg::CH_PERIOD;
      6: return ift_pkg::CH_AMP;
      7: return ift_pkg::CH_QUOTE;
      8: return ift_pkg::CH_COMMA;
      9: return blank_char();
      default: return ift_pkg::CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Well-formed fields with random content, mixed with raw noise
  function automatic void gen_fields(input int budget, input int span);
    int start;
    start = queued_words;
    while (queued_words - start < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 7) == 0) push_eof();
          else push_char(ift_pkg::CHAR_W'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(0, 2)) push_char(blank_char());
        if ($urandom_range(0, 3) == 0) push_char(ift_pkg::CH_QUOTE);
        repeat ($urandom_range(0, span)) push_char(pick_char());
        if ($urandom_range(0, 2) == 0) push_char(ift_pkg::CH_QUOTE);
        case ($urandom_range(0, 6))
          0: push_char(ift_pkg::CH_COMMA);
          1: push_char(ift_pkg::CH_LF);
          2: push_char(ift_pkg::CH_CR);
          3: begin
            push_char(ift_pkg::CH_CR);
            push_char(ift_pkg::CH_LF);
          end
          4: repeat ($urandom_range(1, 3)) push_char(blank_char());
          5: push_eof();
          default: ;
        endcase
      end
    end
  endfunction

  // Hold until every queued word is taken and every result is back
  task automatic wait_idle();
    do @(negedge clk); while (send_q.size() != 0 || in_valid || field_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ift_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ift_pkg::LEN_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      ift_pkg::CFG_STRING_MODE: str_mode = val[0];
      ift_pkg::CFG_FIELD_LIMIT: lim_reg = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic mode, input logic [ift_pkg::LEN_W-1:0] limit);
    wait_idle();
    write_reg(ift_pkg::CFG_STRING_MODE, ift_pkg::LEN_W'(mode));
    write_reg(ift_pkg::CFG_FIELD_LIMIT, limit);
  endtask

  // Driver: bursts of words with random gaps in between
  always @(posedge clk) begin
    ift_pkg::result_t r;
    ift_pkg::item_t   nxt;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        words_accepted++;
        if (tokenize(in_char_code, in_end_of_file, r)) field_q.push_back(r);
      end
      if (!in_valid || in_ready) begin
        if (send_q.size() != 0 && gap_left == 0) begin
          nxt = send_q.pop_front();
          in_valid       <= 1'b1;
          in_char_code   <= nxt.char_code;
          in_end_of_file <= nxt.end_of_file;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end
      end
    end
  end

  // Monitor: check each result word, then pick the next ready value
  always @(posedge clk) begin
    ift_pkg::result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_field_end) fields_closed++;
        if (field_q.size() == 0) begin
          report($sformatf("result word with nothing pending (char %0h)", out_char));
        end else begin
          want = field_q.pop_front();
          check_field("out_char", 16'(out_char), 16'(want.out_char));
          check_field("char_valid", 16'(out_char_valid), 16'(want.char_valid));
          check_field("field_end", 16'(out_field_end), 16'(want.field_end));
          check_field("looks_float", 16'(out_looks_float), 16'(want.looks_float));
          check_field("field_length", 16'(out_field_length), 16'(want.field_length));
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_done < 2 && results_seen >= hold_mark && send_q.size() > 60) begin
        // long hold-off while the sender keeps offering: fills the block
        hold_left = LONG_HOLD;
        hold_mark = results_seen + 250;
        holds_done++;
        out_ready <= 1'b0;
      end else begin
        stall_tick++;
        case (stall_tick[7:6])
          2'd0: out_ready <= 1'b1;
          2'd1: out_ready <= 1'($urandom_range(0, 1));
          2'd2: out_ready <= (stall_tick[1:0] == 2'd0);
          default: out_ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic                      set_mode [NUM_SETS];
    logic [ift_pkg::LEN_W-1:0] set_limit[NUM_SETS];
    int                        eff;

    set_mode  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    set_limit = '{ift_pkg::FIELD_LIMIT_RESET, ift_pkg::LEN_W'(0), ift_pkg::LEN_W'(3),
                  ift_pkg::LEN_W'(9), ift_pkg::LEN_W'(MAX_FIELD),
                  ift_pkg::LEN_W'(ift_pkg::LIMIT_REG_MAX), ift_pkg::LEN_W'(1),
                  ift_pkg::LEN_W'(20)};

    str_mode  = 1'b0;
    lim_reg   = ift_pkg::FIELD_LIMIT_RESET;
    tok_phase = ift_pkg::PH_IDLE;
    clear_field();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Numeric mode at reset settings: skip, rewrite, quotes, CRLF, end of file
    push_text(" 1d2,");
    push_text("\"a,\"b c");
    push_text("\"&d");
    push_char(ift_pkg::CH_CR);
    push_char(ift_pkg::CH_LF);
    push_char(8'hFF);
    push_char(8'h00);
    push_eof();
    push_eof();

    // String mode: blanks kept inside quotes, closing quote ends, CR then text
    wait_idle();
    write_reg(ift_pkg::CFG_STRING_MODE, ift_pkg::LEN_W'(1));
    push_text("\"x y\" z");
    push_char(ift_pkg::CH_CR);
    push_text("7");
    push_eof();

    // Lower the limit in the middle of a field, then limit zero
    configure(1'b0, ift_pkg::FIELD_LIMIT_RESET);
    push_text("abc");
    wait_idle();
    write_reg(ift_pkg::CFG_FIELD_LIMIT, ift_pkg::LEN_W'(2));
    push_text("d,");
    wait_idle();
    write_reg(ift_pkg::CFG_FIELD_LIMIT, ift_pkg::LEN_W'(0));
    push_text("xy");
    push_char(ift_pkg::CH_LF);

    for (int s = 0; s < NUM_SETS; s++) begin
      configure(set_mode[s], set_limit[s]);
      eff = (set_limit[s] == 0) ? 1 :
            ((set_limit[s] > MAX_FIELD) ? MAX_FIELD : int'(set_limit[s]));
      gen_fields(WORDS_PER_SET, (eff < 10) ? eff + 2 : 12);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words in both modes over %0d register writes, limits 0 to %0d.",
             words_accepted, cfg_writes, ift_pkg::LIMIT_REG_MAX);
    $display("Checked %0d result words closing %0d fields; %0d mismatches.",
             results_seen, fields_closed, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
